// ===== hw/rtl/ihrc_pkg.sv =====
// ihrc_pkg: shared types, codes and constants of the ipv4 header receive checker
// no dependencies; used by the interfaces and by every ihrc module
package ihrc_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned IHL_W   = 4;
   localparam int unsigned SUM_W   = 16;

   localparam logic [3:0]         IP_VERSION     = 4'd4;
   localparam logic [IHL_W-1:0]   MIN_IHL        = 4'd5;
   localparam logic [ADDR_W-1:0]  BROADCAST_ADDR = 32'hffff_ffff;
   localparam logic [SUM_W-1:0]   SUM_GOOD       = 16'hffff;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hffff;
   localparam logic [COUNT_W-1:0] TTL_INDEX      = 16'd8;
   localparam logic [COUNT_W-1:0] DEST_FIRST     = 16'd16;
   localparam logic [COUNT_W-1:0] DEST_LAST      = 16'd19;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_VERSION  = 3'd1,
      ERR_HEADLEN  = 3'd2,
      ERR_TTL      = 3'd3,
      ERR_DEST     = 3'd4,
      ERR_CHECKSUM = 3'd5,
      ERR_TRUNC    = 3'd6
   } err_type;

   // one packet byte as held in the input register
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } stage_type;

   // verdict handed from the header tracker to the result register
   typedef struct packed {
      logic               valid;
      logic               accept;
      err_type            error_code;
      logic [COUNT_W-1:0] packet_bytes;
   } verdict_type;

endpackage

// ===== hw/rtl/ihrc_if.sv =====
// ihrc channel interfaces: request bytes, response verdicts, csr writes
// depends on ihrc_pkg
interface ihrc_req_if;
   import ihrc_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihrc_rsp_if;
   import ihrc_pkg::*;
   logic               valid;
   logic               ready;
   logic               accept;
   logic [2:0]         error_code;
   logic [COUNT_W-1:0] packet_bytes;
   modport source (output valid, output accept, output error_code, output packet_bytes,
                   input ready);
   modport sink   (input valid, input accept, input error_code, input packet_bytes,
                   output ready);
endinterface

interface ihrc_csr_if;
   import ihrc_pkg::*;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ihrc_in_reg.sv =====
// ihrc_in_reg: input register for request beats, freed as the tracker consumes them
// depends on ihrc_pkg and ihrc_req_if
module ihrc_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   ihrc_req_if.sink              req_if,
   input  logic                  stage_done,
   output ihrc_pkg::stage_type   stage
);
   import ihrc_pkg::*;

   stage_type stage_ff, stage_in;
   logic      take;

   assign req_if.ready = !stage_ff.valid || stage_done;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      stage_in = stage_ff;
      if (take) begin
         stage_in.valid     = 1'b1;
         stage_in.data_byte = req_if.data_byte;
         stage_in.last_byte = req_if.last_byte;
      end else if (stage_done) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.data_byte <= stage_in.data_byte;
      stage_ff.last_byte <= stage_in.last_byte;
   end

   assign stage = stage_ff;

endmodule

// ===== hw/rtl/ihrc_track.sv =====
// ihrc_track: per-packet header state, running checksum and verdict logic
// depends on ihrc_pkg
module ihrc_track (
   input  logic                       clock,
   input  logic                       reset,
   input  ihrc_pkg::stage_type        stage,
   input  logic                       out_free,
   input  logic [ihrc_pkg::ADDR_W-1:0] local_address,
   output logic                       stage_done,
   output ihrc_pkg::verdict_type      verdict
);
   import ihrc_pkg::*;

   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [IHL_W-1:0]   header_words_ff, header_words_in;
   logic               version_bad_ff, version_bad_in;
   logic               ttl_zero_ff, ttl_zero_in;
   logic [ADDR_W-1:0]  dest_shift_ff, dest_shift_in;
   logic [SUM_W-1:0]   sum_acc_ff, sum_acc_in;
   logic [BYTE_W-1:0]  high_byte_hold_ff, high_byte_hold_in;

   logic [COUNT_W-1:0] idx;
   logic [BYTE_W-1:0]  b;
   logic [IHL_W+1:0]   header_bytes;
   logic               in_header;
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_folded;
   err_type            code;

   assign idx = byte_count_ff;
   assign b   = stage.data_byte;

   // a last beat waits until the result register can take its verdict
   assign stage_done = stage.valid && (!stage.last_byte || out_free);

   always_comb begin
      header_words_in = (idx == '0) ? b[IHL_W-1:0] : header_words_ff;
      version_bad_in  = (idx == '0) ? (b[7:4] != IP_VERSION) : version_bad_ff;
      ttl_zero_in     = (idx == TTL_INDEX) ? (b == '0) : ttl_zero_ff;
      dest_shift_in   = (idx >= DEST_FIRST && idx <= DEST_LAST) ?
                        {dest_shift_ff[ADDR_W-BYTE_W-1:0], b} : dest_shift_ff;
      header_bytes    = {header_words_in, 2'b00};
      in_header       = idx < {{(COUNT_W-IHL_W-2){1'b0}}, header_bytes};

      // end-around carry: one fold always suffices for a 17-bit sum
      sum_wide   = {1'b0, sum_acc_ff} + {1'b0, high_byte_hold_ff, b};
      sum_folded = sum_wide[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, sum_wide[SUM_W]};

      high_byte_hold_in = (in_header && !idx[0]) ? b : high_byte_hold_ff;
      sum_acc_in        = (in_header && idx[0]) ? sum_folded : sum_acc_ff;
      byte_count_in     = (byte_count_ff == COUNT_MAX) ? byte_count_ff
                                                       : byte_count_ff + 1'b1;

      if (version_bad_in) begin
         code = ERR_VERSION;
      end else if (header_words_in < MIN_IHL) begin
         code = ERR_HEADLEN;
      end else if (byte_count_in < {{(COUNT_W-IHL_W-2){1'b0}}, header_bytes}) begin
         code = ERR_TRUNC;
      end else if (ttl_zero_in) begin
         code = ERR_TTL;
      end else if (dest_shift_in != local_address && dest_shift_in != BROADCAST_ADDR) begin
         code = ERR_DEST;
      end else if (sum_acc_in != SUM_GOOD) begin
         code = ERR_CHECKSUM;
      end else begin
         code = ERR_NONE;
      end

      verdict.valid        = stage_done && stage.last_byte;
      verdict.accept       = (code == ERR_NONE);
      verdict.error_code   = code;
      verdict.packet_bytes = byte_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (stage_done && stage.last_byte)) begin
         byte_count_ff     <= '0;
         header_words_ff   <= '0;
         version_bad_ff    <= 1'b0;
         ttl_zero_ff       <= 1'b0;
         dest_shift_ff     <= '0;
         sum_acc_ff        <= '0;
         high_byte_hold_ff <= '0;
      end else if (stage_done) begin
         byte_count_ff     <= byte_count_in;
         header_words_ff   <= header_words_in;
         version_bad_ff    <= version_bad_in;
         ttl_zero_ff       <= ttl_zero_in;
         dest_shift_ff     <= dest_shift_in;
         sum_acc_ff        <= sum_acc_in;
         high_byte_hold_ff <= high_byte_hold_in;
      end
   end

endmodule

// ===== hw/rtl/ihrc_out_reg.sv =====
// ihrc_out_reg: result register driving the response channel
// depends on ihrc_pkg and ihrc_rsp_if
module ihrc_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  ihrc_pkg::verdict_type verdict,
   output logic                  out_free,
   ihrc_rsp_if.source            rsp_if
);
   import ihrc_pkg::*;

   verdict_type rsp_ff, rsp_in;

   assign out_free = !rsp_ff.valid || rsp_if.ready;

   always_comb begin
      rsp_in = rsp_ff;
      if (verdict.valid) begin
         rsp_in = verdict;
      end else if (rsp_if.ready) begin
         rsp_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.accept       <= rsp_in.accept;
      rsp_ff.error_code   <= rsp_in.error_code;
      rsp_ff.packet_bytes <= rsp_in.packet_bytes;
   end

   assign rsp_if.valid        = rsp_ff.valid;
   assign rsp_if.accept       = rsp_ff.accept;
   assign rsp_if.error_code   = rsp_ff.error_code;
   assign rsp_if.packet_bytes = rsp_ff.packet_bytes;

endmodule

// ===== hw/rtl/ipv4_header_receive_checker_unit.sv =====
// ipv4_header_receive_checker_unit: top level of the ipv4 header receive checker
// depends on ihrc_pkg, the ihrc interfaces, ihrc_in_reg, ihrc_track, ihrc_out_reg
//
//   channel   dir  beat contents                          handshake
//   req_if    in   data_byte[7:0], last_byte             valid/ready
//   rsp_if    out  accept, error_code[2:0], packet_bytes  valid/ready
//   csr_if    in   data[31:0] = local_address             valid/ready (ready tied high)
//
// one packet byte per cycle, unless a last byte waits for the result register; a verdict
// leaves through the input register, then the tracker logic into the result register
// reset is synchronous and active high; it clears the packet state and local_address
// a waiting verdict only holds back the next last byte, which waits in the input
// register; ordinary bytes keep flowing while the response side stalls
module ipv4_header_receive_checker_unit (
   input  logic       clock,
   input  logic       reset,
   ihrc_req_if.sink   req_if,
   ihrc_rsp_if.source rsp_if,
   ihrc_csr_if.sink   csr_if
);
   import ihrc_pkg::*;

   // this host's address; the user must write it only while the block is idle (not enforced)
   logic [ADDR_W-1:0] local_address_ff;

   stage_type   stage;
   verdict_type verdict;
   logic        stage_done;
   logic        out_free;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff <= '0;
      end else if (csr_if.valid) begin
         local_address_ff <= csr_if.data;
      end
   end

   // input register: holds one byte until the tracker consumes it
   ihrc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .stage_done (stage_done),
      .stage      (stage)
   );

   // header fields, checksum and the verdict for the last byte
   ihrc_track u_track (
      .clock         (clock),
      .reset         (reset),
      .stage         (stage),
      .out_free      (out_free),
      .local_address (local_address_ff),
      .stage_done    (stage_done),
      .verdict       (verdict)
   );

   // result register toward the response channel
   ihrc_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .verdict  (verdict),
      .out_free (out_free),
      .rsp_if   (rsp_if)
   );

   // a last byte leaving the input register always yields a verdict next cycle
   assert property (@(posedge clock) disable iff (reset)
      (stage.valid && stage.last_byte && stage_done) |=> rsp_if.valid)
      else $error("verdict missing after last byte");

   // accept and a clean error code go together
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.accept == (rsp_if.error_code == ERR_NONE)))
      else $error("accept disagrees with error code");

   // every packet counts at least its last byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.packet_bytes != '0))
      else $error("empty packet count");

   // input side only stalls while a byte is parked in the input register
   assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> stage.valid)
      else $error("input stalled with empty input register");

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for the ipv4 header receive checker, byte beats in,
// verdict beats out, compared against an in-bench model of the header checks
// depends on ihrc_pkg, the ihrc interfaces and ipv4_header_receive_checker_unit
module tb_top;
   import ihrc_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 4;
   // tail after the last verdict, past the input and result registers
   localparam int DRAIN_CYCLES = 4;
   localparam int STALL_LIMIT  = 5000;
   localparam int PHASE_BYTES  = 250;

   typedef enum {DST_LOCAL, DST_BCAST, DST_OTHER} dest_kind_type;
   typedef enum {FAULT_VERSION, FAULT_IHL, FAULT_TTL, FAULT_DEST, FAULT_SUM, FAULT_SHORT}
      fault_type;

   typedef struct packed {
      logic               accept;
      err_type            code;
      logic [COUNT_W-1:0] bytes;
   } exp_verdict_type;

   // one directed packet; typed rows carry a verdict that is plain from the header
   typedef struct {
      logic [3:0]         version;
      logic [IHL_W-1:0]   ihl;
      logic [7:0]         ttl;
      dest_kind_type      dest;
      bit                 bad_sum;
      int                 length;
      bit                 typed;
      logic               accept;
      err_type            code;
      logic [COUNT_W-1:0] bytes;
   } packet_case_type;

   packet_case_type packet_cases [19] = '{
      // clean header to local and broadcast
      '{4'd4,  4'd5,  8'd64,  DST_LOCAL, 1'b0, 20,    1'b1, 1'b1, ERR_NONE,     16'd20},
      '{4'd4,  4'd5,  8'd1,   DST_BCAST, 1'b0, 20,    1'b1, 1'b1, ERR_NONE,     16'd20},
      // version and header length errors, single-byte packets among them
      '{4'd6,  4'd5,  8'd64,  DST_LOCAL, 1'b0, 20,    1'b1, 1'b0, ERR_VERSION,  16'd20},
      '{4'd0,  4'd0,  8'd64,  DST_LOCAL, 1'b0, 1,     1'b1, 1'b0, ERR_VERSION,  16'd1},
      '{4'd4,  4'd0,  8'd64,  DST_LOCAL, 1'b0, 1,     1'b1, 1'b0, ERR_HEADLEN,  16'd1},
      '{4'd4,  4'd4,  8'd64,  DST_LOCAL, 1'b0, 20,    1'b1, 1'b0, ERR_HEADLEN,  16'd20},
      // packet ends inside the header, then a full 60-byte header
      '{4'd4,  4'd5,  8'd64,  DST_LOCAL, 1'b0, 1,     1'b1, 1'b0, ERR_TRUNC,    16'd1},
      '{4'd4,  4'd5,  8'd64,  DST_LOCAL, 1'b0, 19,    1'b1, 1'b0, ERR_TRUNC,    16'd19},
      '{4'd4,  4'd15, 8'd64,  DST_LOCAL, 1'b0, 59,    1'b1, 1'b0, ERR_TRUNC,    16'd59},
      '{4'd4,  4'd15, 8'd64,  DST_BCAST, 1'b0, 60,    1'b1, 1'b1, ERR_NONE,     16'd60},
      // ttl extremes, foreign destination, bad checksum
      '{4'd4,  4'd5,  8'd0,   DST_LOCAL, 1'b0, 20,    1'b1, 1'b0, ERR_TTL,      16'd20},
      '{4'd4,  4'd5,  8'd255, DST_LOCAL, 1'b0, 20,    1'b1, 1'b1, ERR_NONE,     16'd20},
      '{4'd4,  4'd5,  8'd64,  DST_OTHER, 1'b0, 20,    1'b1, 1'b0, ERR_DEST,     16'd20},
      '{4'd4,  4'd5,  8'd64,  DST_LOCAL, 1'b1, 20,    1'b0, 1'b0, ERR_NONE,     16'd0},
      // several faults at once: the first in check order wins; then a bad checksum alone
      '{4'd15, 4'd15, 8'd0,   DST_OTHER, 1'b1, 60,    1'b1, 1'b0, ERR_VERSION,  16'd60},
      '{4'd4,  4'd5,  8'd0,   DST_OTHER, 1'b1, 20,    1'b1, 1'b0, ERR_TTL,      16'd20},
      '{4'd4,  4'd5,  8'd64,  DST_OTHER, 1'b1, 20,    1'b1, 1'b0, ERR_DEST,     16'd20},
      '{4'd4,  4'd5,  8'd0,   DST_LOCAL, 1'b0, 10,    1'b1, 1'b0, ERR_TRUNC,    16'd10},
      '{4'd4,  4'd6,  8'd128, DST_BCAST, 1'b1, 100,   1'b0, 1'b0, ERR_NONE,     16'd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   ihrc_req_if req_if ();
   ihrc_rsp_if rsp_if ();
   ihrc_csr_if csr_if ();

   ipv4_header_receive_checker_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #HALF_PERIOD clock = ~clock;

   // model state of the checker: host address plus the per-packet trackers
   logic [ADDR_W-1:0]  host_addr;
   logic [COUNT_W-1:0] seen_bytes;
   logic [IHL_W-1:0]   hdr_words;
   logic               version_wrong;
   logic               ttl_expired;
   logic [ADDR_W-1:0]  dest_addr;
   logic [SUM_W-1:0]   hdr_sum;
   logic [BYTE_W-1:0]  hi_byte;

   exp_verdict_type   expected_verdicts [$];
   logic [BYTE_W-1:0] packet_buf [$];

   int send_idle_pct;
   int recv_idle_pct;
   int phase_bytes;
   int idle_cycles;
   int mismatches;

   function automatic void clear_packet_state();
      seen_bytes    = '0;
      hdr_words     = '0;
      version_wrong = 1'b0;
      ttl_expired   = 1'b0;
      dest_addr     = '0;
      hdr_sum       = '0;
      hi_byte       = '0;
   endfunction

   // advance the model by one accepted byte; returns 1 with the verdict on the last byte
   function automatic bit track_header_byte(input logic [BYTE_W-1:0] b, input logic last,
                                            output exp_verdict_type v);
      logic [COUNT_W-1:0] idx;
      logic [COUNT_W-1:0] hdr_len;
      logic [SUM_W:0]     s;
      err_type            code;
      idx = seen_bytes;
      v   = '0;
      if (idx == 0) begin
         version_wrong = b[7:4] != IP_VERSION;
         hdr_words     = b[3:0];
      end
      if (idx == TTL_INDEX) ttl_expired = (b == 8'd0);
      if (idx >= DEST_FIRST && idx <= DEST_LAST) dest_addr = {dest_addr[ADDR_W-9:0], b};
      hdr_len = {10'd0, hdr_words, 2'b00};
      // ones-complement sum over big-endian header words, carry folded back in
      if (idx < hdr_len) begin
         if (!idx[0]) begin
            hi_byte = b;
         end else begin
            s       = {1'b0, hdr_sum} + {1'b0, hi_byte, b};
            hdr_sum = s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
         end
      end
      if (seen_bytes != COUNT_MAX) seen_bytes++;
      if (!last) return 1'b0;

      if (version_wrong)                   code = ERR_VERSION;
      else if (hdr_words < MIN_IHL)        code = ERR_HEADLEN;
      else if (seen_bytes < hdr_len)       code = ERR_TRUNC;
      else if (ttl_expired)                code = ERR_TTL;
      else if (dest_addr != host_addr && dest_addr != BROADCAST_ADDR)
                                           code = ERR_DEST;
      else if (hdr_sum != SUM_GOOD)        code = ERR_CHECKSUM;
      else                                 code = ERR_NONE;

      v.accept = (code == ERR_NONE);
      v.code   = code;
      v.bytes  = seen_bytes;
      clear_packet_state();
      return 1'b1;
   endfunction

   // fills packet_buf with a header of the given fields, then payload or a cut
   task automatic build_packet(input logic [3:0] version, input logic [IHL_W-1:0] ihl,
                               input logic [7:0] ttl, input dest_kind_type dk,
                               input bit bad_sum, input int length);
      int                hdr;
      int                s;
      logic [ADDR_W-1:0] dest;
      logic [SUM_W-1:0]  csum;
      hdr = (ihl >= MIN_IHL) ? ihl * 4 : 20;
      packet_buf.delete();
      repeat (hdr) packet_buf.push_back(8'($urandom_range(255)));
      packet_buf[0]  = {version, ihl};
      packet_buf[8]  = ttl;
      packet_buf[10] = 8'd0;
      packet_buf[11] = 8'd0;
      case (dk)
         DST_LOCAL: dest = host_addr;
         DST_BCAST: dest = BROADCAST_ADDR;
         default: begin
            do dest = $urandom; while (dest == host_addr || dest == BROADCAST_ADDR);
         end
      endcase
      for (int i = 0; i < 4; i++) packet_buf[16+i] = dest[31-8*i -: 8];
      if (ihl >= MIN_IHL) begin
         s = 0;
         for (int i = 0; i < ihl * 4; i += 2) begin
            s += {packet_buf[i], packet_buf[i+1]};
            s = (s & 32'hffff) + (s >> 16);
         end
         csum = ~s[15:0];
         if (bad_sum) csum ^= 16'($urandom_range(16'hffff, 1));
         packet_buf[10] = csum[15:8];
         packet_buf[11] = csum[7:0];
      end
      while (packet_buf.size() < length) packet_buf.push_back(8'($urandom_range(255)));
      while (packet_buf.size() > length) void'(packet_buf.pop_back());
   endtask

   // one byte beat; called at a rising edge, returns at the edge that took it
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                            output bit has_v, output exp_verdict_type v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.last_byte <= last;
      // handshake looked at mid-cycle, where nothing is moving
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
      has_v = track_header_byte(b, last, v);
      phase_bytes++;
   endtask

   task automatic send_packet(input bit typed, input exp_verdict_type typed_v);
      bit              has_v;
      exp_verdict_type v;
      foreach (packet_buf[i]) begin
         send_byte(packet_buf[i], i == packet_buf.size() - 1, has_v, v);
         if (has_v) expected_verdicts.push_back(typed ? typed_v : v);
      end
   endtask

   // mostly clean packets, some with one fault, the rest raw noise
   task automatic send_random_packet();
      int               pick;
      int               hdr;
      int               len;
      logic [3:0]       version;
      logic [IHL_W-1:0] ihl;
      logic [7:0]       ttl;
      dest_kind_type    dk;
      bit               bad_sum;
      version = IP_VERSION;
      ihl     = ($urandom_range(3) == 0) ? IHL_W'($urandom_range(15, 5)) : MIN_IHL;
      ttl     = 8'($urandom_range(255, 1));
      dk      = $urandom_range(1) ? DST_LOCAL : DST_BCAST;
      bad_sum = 1'b0;
      hdr     = ihl * 4;
      len     = hdr + (($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(12));
      pick    = $urandom_range(99);
      if (pick >= 85) begin
         packet_buf.delete();
         repeat ($urandom_range(40, 1)) packet_buf.push_back(8'($urandom_range(255)));
      end else begin
         if (pick >= 60) begin
            case (fault_type'($urandom_range(5)))
               FAULT_VERSION: begin
                  do version = 4'($urandom); while (version == IP_VERSION);
               end
               FAULT_IHL:   ihl = IHL_W'($urandom_range(4));
               FAULT_TTL:   ttl = 8'd0;
               FAULT_DEST:  dk = DST_OTHER;
               FAULT_SUM:   bad_sum = 1'b1;
               default:     len = $urandom_range(hdr - 1, 1);
            endcase
         end
         build_packet(version, ihl, ttl, dk, bad_sum, len);
      end
      send_packet(1'b0, '0);
   endtask

   // stop feeding bytes and wait for every verdict, plus the pipeline tail
   task automatic drain_verdicts();
      req_if.valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_host_addr(input logic [ADDR_W-1:0] addr);
      csr_if.valid <= 1'b1;
      csr_if.data  <= addr;
      do @(negedge clock); while (!csr_if.ready);
      @(posedge clock);
      csr_if.valid <= 1'b0;
      host_addr = addr;
   endtask

   task automatic run_random_phase(input int s_pct, input int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      phase_bytes   = 0;
      while (phase_bytes < PHASE_BYTES) send_random_packet();
   endtask

   // verdict side back-pressure
   always @(posedge clock) rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);

   // verdict checker and no-progress watchdog
   always @(negedge clock) begin
      exp_verdict_type want;
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_verdicts.size() == 0) begin
               $error("verdict beat with none pending: accept %0b error_code %0d bytes %0d",
                      rsp_if.accept, rsp_if.error_code, rsp_if.packet_bytes);
               mismatches++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_if.accept !== want.accept) begin
                  $error("accept: expected %0b, got %0b", want.accept, rsp_if.accept);
                  mismatches++;
               end
               if (rsp_if.error_code !== want.code) begin
                  $error("error_code: expected %0d, got %0d", want.code, rsp_if.error_code);
                  mismatches++;
               end
               if (rsp_if.packet_bytes !== want.bytes) begin
                  $error("packet_bytes: expected %0d, got %0d", want.bytes,
                         rsp_if.packet_bytes);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      req_if.valid     <= 1'b0;
      req_if.data_byte <= '0;
      req_if.last_byte <= 1'b0;
      csr_if.valid     <= 1'b0;
      csr_if.data      <= '0;
      send_idle_pct = 11;
      recv_idle_pct = 64;
      idle_cycles   = 0;
      mismatches    = 0;
      phase_bytes   = 0;
      host_addr     = '0;
      clear_packet_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed packets run with the reset host address of zero
      foreach (packet_cases[i]) begin
         build_packet(packet_cases[i].version, packet_cases[i].ihl, packet_cases[i].ttl,
                      packet_cases[i].dest, packet_cases[i].bad_sum, packet_cases[i].length);
         send_packet(packet_cases[i].typed,
                     '{packet_cases[i].accept, packet_cases[i].code, packet_cases[i].bytes});
      end

      // random phases: host address at each extreme and one arbitrary value
      drain_verdicts();
      write_host_addr(BROADCAST_ADDR);
      run_random_phase(11, 64);
      drain_verdicts();
      write_host_addr($urandom);
      run_random_phase(64, 11);
      drain_verdicts();
      write_host_addr('0);
      run_random_phase(0, 0);
      drain_verdicts();

      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
